### hw/rtl/mpsq_pkg.sv
// Shared types and constants for the matrix power core.
`timescale 1ns / 1ps
package mpsq_pkg;

  localparam int DATA_W = 32;
  localparam int SIZE_W = 4;
  localparam int EXP_W  = 31;

  // Configuration register indexes
  localparam logic CFG_MATRIX_SIZE = 1'b0;
  localparam logic CFG_EXPONENT    = 1'b1;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic load_base;  // write incoming element into base column
    logic capture;    // latch row of lhs into the pass register
    logic lhs_acc;    // lhs is the accumulator, else the base
    logic step;       // multiply and shift the pass ring
    logic clr_sum;    // clear dot-product sum
    logic wr_scratch; // store sum into scratch row
    logic copy_base;  // scratch row into base row
    logic copy_acc;   // scratch row into accumulator row
    logic init_acc;   // identity row into accumulator row
  } cell_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_INIT,
    S_DECIDE,
    S_CAP,
    S_STEP,
    S_FLUSH,
    S_WRITE,
    S_COPY,
    S_OUT
  } state_t;

endpackage

### hw/rtl/mpsq_cell.sv
// One column cell: holds a column of base, accumulator and scratch, and a MAC lane.
`timescale 1ns / 1ps
module mpsq_cell import mpsq_pkg::*; #(
  parameter int DIM = 8,
  parameter int COL = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctl_t         ctl,
  input  logic [((DIM > 1) ? $clog2(DIM) : 1)-1:0] row,
  input  logic [((DIM > 1) ? $clog2(DIM) : 1)-1:0] nm1,
  input  logic              ld_sel,
  input  logic [DATA_W-1:0] ld_data,
  input  logic [DATA_W-1:0] pass_in,
  output logic [DATA_W-1:0] pass_out,
  output logic [DATA_W-1:0] acc_rd
);

  localparam int RW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam logic [RW-1:0] COL_IDX = RW'(COL);

  logic [DATA_W-1:0] base_mem [DIM];
  logic [DATA_W-1:0] acc_mem  [DIM];
  logic [DATA_W-1:0] scr_mem  [DIM];
  logic [DATA_W-1:0] pass;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] sum;
  logic              prod_vld;
  logic [RW-1:0]     idx;
  logic [RW-1:0]     rd_addr;
  logic [DATA_W-1:0] base_rd;

  // single base read port: row on capture, ring index while stepping
  assign rd_addr  = ctl.step ? idx : row;
  assign base_rd  = base_mem[rd_addr];
  assign pass_out = pass;
  assign acc_rd   = acc_mem[row];

  // pass ring and its column index
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      pass <= ctl.lhs_acc ? acc_mem[row] : base_rd;
      idx  <= COL_IDX;
    end else if (ctl.step) begin
      pass <= pass_in;
      idx  <= (idx == nm1) ? '0 : idx + 1'b1;
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      prod <= pass * base_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctl.step;
    end
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (ctl.clr_sum) begin
      sum <= '0;
    end else if (prod_vld) begin
      sum <= sum + prod;
    end
  end

  // column storage writes
  always_ff @(posedge clk) begin
    if (ctl.load_base && ld_sel) begin
      base_mem[row] <= ld_data;
    end else if (ctl.copy_base) begin
      base_mem[row] <= scr_mem[row];
    end
    if (ctl.init_acc) begin
      acc_mem[row] <= (row == COL_IDX) ? DATA_W'(1) : '0;
    end else if (ctl.copy_acc) begin
      acc_mem[row] <= scr_mem[row];
    end
    if (ctl.wr_scratch) begin
      scr_mem[row] <= sum;
    end
  end

endmodule

### hw/rtl/matrix_power_by_squaring_core.sv
// Matrix power by squaring: size*size items in, size*size result items out.
// After the completing item the load buffer is moved into the cells, the
// accumulator is set to the identity, then the exponent steps run
// (at most 2*floor(log2(exponent))+1 steps) and a final decide state precedes output.
// Throughput: one matrix at a time; one item per cycle in while idle, n*n result items out.
// Reset clears control, size to 1 and exponent to 1; matrix storage is not cleared.
`timescale 1ns / 1ps
module matrix_power_by_squaring_core import mpsq_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] element_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] result_value,
  output logic              last_of_matrix,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [EXP_W-1:0]  cfg_data
);

  localparam int RW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CW    = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t            state, state_next;
  cell_ctl_t         ctl;
  logic [SIZE_W-1:0] matrix_size;
  logic [EXP_W-1:0]  exponent;
  logic [EXP_W-1:0]  exp_left;
  logic              op_sq;
  logic [CW-1:0]     load_cnt;
  logic [CW-1:0]     fill_cnt;
  logic              fill_vld;
  logic [DATA_W-1:0] fill_data;
  logic [DATA_W-1:0] load_mem [DEPTH];
  logic [AW-1:0]     wr_idx;
  logic [RW-1:0]     row, cnt, col;
  logic [RW:0]       n;
  logic [RW-1:0]     nm1;
  logic [CW-1:0]     total;
  logic              in_acc, restart, load_done, out_load, out_last;
  logic [CW-1:0]     cnt_new;
  logic [DATA_W-1:0] pass_out [MAX_DIM];
  logic [DATA_W-1:0] acc_rd   [MAX_DIM];

  // effective size
  always_comb begin
    if (matrix_size == '0) begin
      n = (RW + 1)'(1);
    end else if (matrix_size > MAX_DIM) begin
      n = (RW + 1)'(MAX_DIM);
    end else begin
      n = (RW + 1)'(matrix_size);
    end
  end
  assign nm1   = RW'(n - 1'b1);
  assign total = CW'(n) * CW'(n);

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;

  // flat load position, restart when the count already covers the matrix
  assign restart   = (load_cnt >= total);
  assign wr_idx    = restart ? '0 : AW'(load_cnt);
  assign cnt_new   = restart ? CW'(1) : load_cnt + 1'b1;
  assign load_done = (cnt_new == total);

  assign out_load = (state == S_OUT) && (!out_valid || out_ready);
  assign out_last = (row == nm1) && (col == nm1);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_W'(1);
      exponent    <= EXP_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MATRIX_SIZE: matrix_size <= cfg_data[SIZE_W-1:0];
        CFG_EXPONENT:    exponent    <= cfg_data;
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and cell commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.lhs_acc = !op_sq;
    case (state)
      S_IDLE: begin
        if (in_acc && load_done) state_next = S_FILL;
      end
      S_FILL: begin
        ctl.load_base = fill_vld;
        if (fill_vld && out_last) state_next = S_INIT;
      end
      S_INIT: begin
        ctl.init_acc = 1'b1;
        if (row == nm1) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = (exp_left == '0) ? S_OUT : S_CAP;
      end
      S_CAP: begin
        ctl.capture = 1'b1;
        ctl.clr_sum = 1'b1;
        state_next  = S_STEP;
      end
      S_STEP: begin
        ctl.step = 1'b1;
        if (cnt == nm1) state_next = S_FLUSH;
      end
      S_FLUSH: state_next = S_WRITE;
      S_WRITE: begin
        ctl.wr_scratch = 1'b1;
        state_next = (row == nm1) ? S_COPY : S_CAP;
      end
      S_COPY: begin
        ctl.copy_base = op_sq;
        ctl.copy_acc  = !op_sq;
        if (row == nm1) state_next = S_DECIDE;
      end
      S_OUT: begin
        if (out_load && out_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // load counter
  always_ff @(posedge clk) begin
    if (rst) begin
      load_cnt <= '0;
    end else if (in_acc) begin
      load_cnt <= load_done ? '0 : cnt_new;
    end
  end

  // load buffer in flat order, read back one entry per cycle while filling
  always_ff @(posedge clk) begin
    if (in_acc) begin
      load_mem[wr_idx] <= element_value;
    end
    fill_data <= load_mem[AW'(fill_cnt)];
  end

  // fill read pointer and valid for the registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= '0;
      fill_vld <= 1'b0;
    end else if (state == S_FILL && fill_cnt < total) begin
      fill_cnt <= fill_cnt + 1'b1;
      fill_vld <= 1'b1;
    end else begin
      fill_vld <= 1'b0;
      if (state != S_FILL) fill_cnt <= '0;
    end
  end

  // sequencing counters and exponent
  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= '0;
      cnt      <= '0;
      col      <= '0;
      exp_left <= '0;
      op_sq    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          row <= '0;
          col <= '0;
          if (in_acc && load_done) exp_left <= exponent;
        end
        S_FILL: begin
          if (fill_vld) begin
            col <= (col == nm1) ? '0 : col + 1'b1;
            if (col == nm1) row <= (row == nm1) ? '0 : row + 1'b1;
          end
        end
        S_INIT, S_COPY: row <= (row == nm1) ? '0 : row + 1'b1;
        S_DECIDE: begin
          row <= '0;
          col <= '0;
          if (exp_left != '0) begin
            op_sq <= !exp_left[0];
            exp_left <= exp_left[0] ? exp_left - 1'b1 : exp_left >> 1;
          end
        end
        S_CAP: cnt <= '0;
        S_STEP: cnt <= cnt + 1'b1;
        S_WRITE: row <= (row == nm1) ? '0 : row + 1'b1;
        S_OUT: begin
          if (out_load) begin
            col <= (col == nm1) ? '0 : col + 1'b1;
            if (col == nm1) row <= row + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_value   <= acc_rd[col];
      last_of_matrix <= out_last;
    end
  end

  // chain of column cells, pass ring wraps at the active size
  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    localparam int NXT = (c + 1) % MAX_DIM;
    logic [DATA_W-1:0] pin;
    assign pin = (nm1 == RW'(c)) ? pass_out[0] : pass_out[NXT];
    mpsq_cell #(
      .DIM (MAX_DIM),
      .COL (c)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .row      (row),
      .nm1      (nm1),
      .ld_sel   (col == RW'(c)),
      .ld_data  (fill_data),
      .pass_in  (pin),
      .pass_out (pass_out[c]),
      .acc_rd   (acc_rd[c])
    );
  end

  // checks
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> (cnt <= nm1))
    else $error("step counter beyond matrix size");

  a_load_progress: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (load_cnt != '0) || (state == S_FILL))
    else $error("accepted item neither counted nor started compute");

  a_fill_state: assert property (@(posedge clk) disable iff (rst)
    fill_vld |-> (state == S_FILL))
    else $error("fill data valid outside the fill phase");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_last) |=> (state == S_IDLE))
    else $error("final result did not return to idle");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("input ready while computing");

endmodule

### sim/tb_top.sv
// Self-checking bench for the matrix power core: random matrices, sizes and powers.
`timescale 1ns / 1ps
module tb_top import mpsq_pkg::*; ();

  localparam int MAX_DIM   = 8;
  localparam int CELLS     = MAX_DIM * MAX_DIM;
  localparam int MAX_CYC   = 3000000;
  localparam int SETTLE    = 40;

  typedef logic [DATA_W-1:0] mat_t [CELLS];

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [DATA_W-1:0] element_value;
  logic              out_valid;
  logic              out_ready;
  logic [DATA_W-1:0] result_value;
  logic              last_of_matrix;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [EXP_W-1:0]  cfg_data;

  // pending elements and expected result elements
  logic [DATA_W-1:0] elem_q [$];
  logic [DATA_W-1:0] want_value_q [$];
  logic              want_last_q [$];

  // predictor state
  mat_t              pm_base;
  int unsigned       pm_count;
  logic [SIZE_W-1:0] pm_size;
  logic [EXP_W-1:0]  pm_power;

  int unsigned       n_err;
  int unsigned       n_res;
  int unsigned       n_mat;
  int unsigned       n_cyc;
  int unsigned       send_idle;
  int unsigned       recv_idle;

  matrix_power_by_squaring_core #(.MAX_DIM(MAX_DIM)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .element_value(element_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_value(result_value), .last_of_matrix(last_of_matrix),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // n x n product with 32-bit wraparound, stride-n layout
  function automatic mat_t mat_product(mat_t a, mat_t b, int unsigned n);
    mat_t              p;
    logic [DATA_W-1:0] acc;
    p = a;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        acc = '0;
        for (int k = 0; k < n; k++) acc += a[r*n+k] * b[k*n+c];
        p[r*n+c] = acc;
      end
    end
    return p;
  endfunction

  // take one element; on the completing one, raise to the power and queue results
  task automatic predict_power(logic [DATA_W-1:0] elem);
    int unsigned      n;
    int unsigned      total;
    logic [EXP_W-1:0] left;
    mat_t             acc;
    n = (pm_size == 0) ? 1 : (pm_size > MAX_DIM) ? MAX_DIM : pm_size;
    total = n * n;
    if (pm_count >= total) pm_count = 0;
    pm_base[pm_count] = elem;
    pm_count++;
    if (pm_count < total) return;
    acc = pm_base;
    for (int i = 0; i < total; i++) acc[i] = (i / n == i % n) ? 32'd1 : 32'd0;
    left = pm_power;
    while (left != 0) begin
      if (left[0]) begin
        acc = mat_product(acc, pm_base, n);
        left = left - 1'b1;
      end else begin
        pm_base = mat_product(pm_base, pm_base, n);
        left = left >> 1;
      end
    end
    for (int i = 0; i < total; i++) begin
      want_value_q.push_back(acc[i]);
      want_last_q.push_back(i + 1 == total);
    end
    pm_count = 0;
    n_mat++;
  endtask

  // feed elements from the queue, idling at random
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      element_value <= '0;
    end else begin
      if (in_valid && in_ready) predict_power(element_value);
      if (!in_valid || in_ready) begin
        if (elem_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          element_value <= elem_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // check result items against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_res++;
        if (want_value_q.size() == 0) begin
          n_err++;
          $display("%0t: unexpected item value=%h last=%b", $time, result_value,
                   last_of_matrix);
        end else begin
          if (result_value !== want_value_q[0]) begin
            n_err++;
            $display("%0t: result_value expected %h actual %h", $time,
                     want_value_q[0], result_value);
          end
          if (last_of_matrix !== want_last_q[0]) begin
            n_err++;
            $display("%0t: last_of_matrix expected %b actual %b", $time,
                     want_last_q[0], last_of_matrix);
          end
          void'(want_value_q.pop_front());
          void'(want_last_q.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // stop a hung run
  always @(posedge clk) begin
    n_cyc <= n_cyc + 1;
    if (n_cyc > MAX_CYC) begin
      $display("timeout after %0d cycles", n_cyc);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [EXP_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MATRIX_SIZE) pm_size = data[SIZE_W-1:0];
    else pm_power = data;
  endtask

  // hold until all elements went in and every result came out
  task automatic drain();
    while (elem_q.size() > 0 || in_valid || want_value_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] rand_elem();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3, 4: return $urandom_range(7) - 3;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [EXP_W-1:0] rand_power();
    case ($urandom_range(9))
      0: return '1;
      1: return EXP_W'($urandom);
      2: return '0;
      default: return EXP_W'($urandom_range(40));
    endcase
  endfunction

  function automatic int unsigned rand_size();
    case ($urandom_range(19))
      0: return 0;
      1: return 8;
      2: return $urandom_range(15, 9);
      3, 4: return $urandom_range(7, 5);
      default: return $urandom_range(4, 1);
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned sz;
    int unsigned n;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_MATRIX_SIZE;
    cfg_data = '0;
    n_err = 0; n_res = 0; n_mat = 0;
    send_idle = 10; recv_idle = 55;
    pm_count = 0; pm_size = 1; pm_power = 1;
    foreach (pm_base[i]) pm_base[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, identity, extremes, size clamps, restart on resize
    elem_q.push_back(32'h8000_0000);
    drain();
    write_reg(CFG_MATRIX_SIZE, EXP_W'(2));
    write_reg(CFG_EXPONENT, '0);
    elem_q = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0};
    drain();
    write_reg(CFG_EXPONENT, EXP_W'(3));
    elem_q = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h1};
    drain();
    write_reg(CFG_EXPONENT, 31'h4000_0000);
    elem_q = '{32'h1, 32'h1, 32'h1, 32'h0};
    drain();
    write_reg(CFG_MATRIX_SIZE, '0);
    write_reg(CFG_EXPONENT, '1);
    elem_q.push_back(32'hffff_ffff);
    drain();
    write_reg(CFG_MATRIX_SIZE, EXP_W'(3));
    write_reg(CFG_EXPONENT, EXP_W'(2));
    for (int i = 0; i < 5; i++) elem_q.push_back(rand_elem());
    drain();
    write_reg(CFG_MATRIX_SIZE, EXP_W'(2));
    for (int i = 0; i < 4; i++) elem_q.push_back(rand_elem());
    drain();

    // directed: partial load kept across a shrink and across a growth of the size
    write_reg(CFG_MATRIX_SIZE, EXP_W'(4));
    write_reg(CFG_EXPONENT, EXP_W'(3));
    for (int i = 0; i < 3; i++) elem_q.push_back(rand_elem());
    drain();
    write_reg(CFG_MATRIX_SIZE, EXP_W'(2));
    elem_q.push_back(rand_elem());
    drain();
    for (int i = 0; i < 3; i++) elem_q.push_back(rand_elem());
    drain();
    write_reg(CFG_MATRIX_SIZE, EXP_W'(3));
    for (int i = 0; i < 6; i++) elem_q.push_back(rand_elem());
    drain();

    // random matrices over three idling patterns
    sent = 0;
    while (sent < 280) begin
      if (sent >= 190) begin
        send_idle = 0; recv_idle = 0;
      end else if (sent >= 95) begin
        send_idle = 55; recv_idle = 10;
      end
      sz = rand_size();
      write_reg(CFG_MATRIX_SIZE, EXP_W'(sz));
      write_reg(CFG_EXPONENT, rand_power());
      n = (sz == 0) ? 1 : (sz > MAX_DIM) ? MAX_DIM : sz;
      repeat ($urandom_range(2, 1)) begin
        for (int i = 0; i < n * n; i++) elem_q.push_back(rand_elem());
        sent += n * n;
      end
      drain();
    end

    $display("covered %0d matrices, %0d result items, sizes 0..15, powers 0..2^31-1",
             n_mat, n_res);
    if (n_err == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
